/* hdl/adb_packet_deframer_checker_core_assert.svh */
// assertion macros shared by the deframer checker modules
`ifndef ADB_PACKET_DEFRAMER_CHECKER_CORE_ASSERT_SVH
`define ADB_PACKET_DEFRAMER_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ADB_DFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adb deframer assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ADB_DFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adb deframer assertion failed");

`endif

/* hdl/adb_dfc_pkg.sv */
// shared types and constants of the adb deframer checker
package adb_dfc_pkg;

    localparam int HEADER_BYTES    = 24;
    localparam int HDR_CNT_W       = 5;
    localparam int WORD_W          = 32;
    localparam int HDR_WORDS       = 6;
    localparam int MAXP_W          = 21;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(4096);

    // header word positions
    localparam int W_CMD   = 0;
    localparam int W_ARG0  = 1;
    localparam int W_ARG1  = 2;
    localparam int W_LEN   = 3;
    localparam int W_SUM   = 4;
    localparam int W_MAGIC = 5;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP_HDR,
        PH_PAYLOAD,
        PH_SKIP_TAIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_SUM_BAD   = 3'd3,
        ST_SHORT     = 3'd4
    } status_t;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // one queue entry: what one accepted byte causes
    typedef struct packed {
        logic              has_byte;
        logic              has_sum;
        logic [7:0]        data;
        logic [WORD_W-1:0] cmd;
        logic [WORD_W-1:0] arg0;
        logic [WORD_W-1:0] arg1;
        logic [WORD_W-1:0] len;
        status_t           status;
    } entry_t;

endpackage

/* hdl/adb_dfc_in_if.sv */
// byte stream channel carrying received bulk data
interface adb_dfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

/* hdl/adb_dfc_out_if.sv */
// result channel carrying payload bytes and packet summaries
interface adb_dfc_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [31:0] command_word;
    logic [31:0] first_arg;
    logic [31:0] second_arg;
    logic [31:0] payload_length;
    logic [2:0]  status;
    logic        is_last;

    modport source (
        output valid, output item_kind, output payload_byte, output command_word,
        output first_arg, output second_arg, output payload_length, output status,
        output is_last, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input command_word,
        input first_arg, input second_arg, input payload_length, input status,
        input is_last, output ready
    );
endinterface

/* hdl/adb_packet_deframer_checker_core.sv */
// top level of the adb message deframer and checksum checker
// takes the bulk receive stream one byte per transaction, with chunk_end on the last byte
// of each usb transfer chunk. the first 24 bytes of a header chunk give six little-endian
// words (command, arg0, arg1, length, checksum, magic); the rest of that chunk is dropped.
// at the header chunk end the magic is checked against the inverted command, then the
// length against the payload length limit. payload bytes are passed out as kind 0 results
// and summed modulo 2^32; at the end of the chunk where the count reaches the length a
// kind 1 summary with status goes out, bytes past the length are ignored. a chunk end
// before 24 header bytes gives a short header summary. one input byte is taken every cycle
// while the queue has room; rx_stream.ready is low in any cycle the queue is full. a byte
// that yields both a payload byte and its summary gives two result transactions, and a
// queue of QUEUE_DEPTH entries between the front and back ends soaks that up. an
// accepted byte is first written into the queue, then moved into the output register
// that drives result valid. the length limit is written through cfg_we / cfg_wdata
// and resets to 4096.
module adb_packet_deframer_checker_core
    import adb_dfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MAXP_W-1:0] cfg_wdata,
    adb_dfc_in_if.sink        rx_stream,
    adb_dfc_out_if.source     result
);

    // queue handshake between front and back
    logic   q_push;
    entry_t q_push_entry;
    logic   q_full;
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;

    // front: header capture, checks and payload accounting, one byte per cycle while the queue has room
    adb_dfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rx         (rx_stream),
        .push       (q_push),
        .push_entry (q_push_entry),
        .queue_full (q_full)
    );

    // decoupling queue, one entry per byte that causes any result
    adb_dfc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // back: splits entries into byte and summary transactions behind an output register
    adb_dfc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .tx      (result)
    );

endmodule

/* hdl/adb_dfc_fifo.sv */
// short queue between the classifying front and the result back end
`include "adb_packet_deframer_checker_core_assert.svh"
module adb_dfc_fifo
    import adb_dfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // the front only pushes when it saw room
    `ADB_DFC_ASSERT_NOW(a_fifo_no_overflow, clk, rst_n, push, !full)

endmodule

/* hdl/adb_dfc_front.sv */
// front end: header capture, checks, payload count and sum
`include "adb_packet_deframer_checker_core_assert.svh"
module adb_dfc_front
    import adb_dfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MAXP_W-1:0] cfg_wdata,
    adb_dfc_in_if.sink        rx,
    output logic              push,
    output entry_t            push_entry,
    input  logic              queue_full
);

    localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(HEADER_BYTES);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [HDR_CNT_W-1:0]   hc_reg;
    logic [HDR_CNT_W-1:0]   hc_next;
    logic [WORD_W-1:0]      hw_reg  [HDR_WORDS];
    logic [WORD_W-1:0]      hw_next [HDR_WORDS];
    logic [MAXP_W-1:0]      bc_reg;
    logic [MAXP_W-1:0]      bc_next;
    logic [WORD_W-1:0]      sum_reg;
    logic [WORD_W-1:0]      sum_next;
    logic [MAXP_W-1:0]      maxp_reg;
    logic                   accept;
    logic                   emit_byte;
    logic                   emit_sum;
    logic                   hdr_check;
    status_t                st;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && !queue_full;
    assign push     = accept && (emit_byte || emit_sum);

    always_comb
    begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        hw_next    = hw_reg;
        bc_next    = bc_reg;
        sum_next   = sum_reg;
        emit_byte  = 1'b0;
        emit_sum   = 1'b0;
        hdr_check  = 1'b0;
        st         = ST_OK;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hc_reg < HDR_LIMIT)
                begin
                    for (int w = 0; w < HDR_WORDS; w++)
                    begin
                        if (hc_reg[4:2] == 3'(w))
                        begin
                            hw_next[w][{hc_reg[1:0], 3'b000} +: 8] = rx.data_byte;
                        end
                    end
                    hc_next = hc_reg + 1'b1;
                end
                if (hc_next >= HDR_LIMIT)
                begin
                    phase_next = PH_SKIP_HDR;
                end
                if (rx.chunk_end)
                begin
                    if (hc_next < HDR_LIMIT)
                    begin
                        emit_sum = 1'b1;
                        st       = ST_SHORT;
                    end
                    else
                    begin
                        hdr_check = 1'b1;
                    end
                end
            end
            PH_SKIP_HDR:
            begin
                hdr_check = rx.chunk_end;
            end
            PH_PAYLOAD:
            begin
                emit_byte = 1'b1;
                sum_next  = sum_reg + WORD_W'(rx.data_byte);
                bc_next   = bc_reg + 1'b1;
                if (bc_next == hw_reg[W_LEN][MAXP_W-1:0])
                begin
                    if (rx.chunk_end)
                    begin
                        emit_sum = 1'b1;
                        st       = (sum_next == hw_reg[W_SUM]) ? ST_OK : ST_SUM_BAD;
                    end
                    else
                    begin
                        phase_next = PH_SKIP_TAIL;
                    end
                end
            end
            PH_SKIP_TAIL:
            begin
                if (rx.chunk_end)
                begin
                    emit_sum = 1'b1;
                    st       = (sum_reg == hw_reg[W_SUM]) ? ST_OK : ST_SUM_BAD;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        // header checks, bad magic ahead of too long
        if (hdr_check)
        begin
            if (hw_next[W_MAGIC] != ~hw_next[W_CMD])
            begin
                emit_sum = 1'b1;
                st       = ST_BAD_MAGIC;
            end
            else if (hw_next[W_LEN] > WORD_W'(maxp_reg))
            begin
                emit_sum = 1'b1;
                st       = ST_TOO_LONG;
            end
            else if (hw_next[W_LEN] == '0)
            begin
                emit_sum = 1'b1;
                st       = (hw_next[W_SUM] == '0) ? ST_OK : ST_SUM_BAD;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
                bc_next    = '0;
                sum_next   = '0;
            end
        end

        push_entry.has_byte = emit_byte;
        push_entry.has_sum  = emit_sum;
        push_entry.data     = rx.data_byte;
        push_entry.cmd      = hw_next[W_CMD];
        push_entry.arg0     = hw_next[W_ARG0];
        push_entry.arg1     = hw_next[W_ARG1];
        push_entry.len      = hw_next[W_LEN];
        push_entry.status   = st;

        // a summary closes the packet
        if (emit_sum)
        begin
            phase_next = PH_HEADER;
            hc_next    = '0;
            bc_next    = '0;
            sum_next   = '0;
            for (int w = 0; w < HDR_WORDS; w++)
            begin
                hw_next[w] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxp_reg  <= MAXP_RESET;
            phase_reg <= PH_HEADER;
            hc_reg    <= '0;
            bc_reg    <= '0;
            sum_reg   <= '0;
            for (int w = 0; w < HDR_WORDS; w++)
            begin
                hw_reg[w] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                maxp_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                hc_reg    <= hc_next;
                bc_reg    <= bc_next;
                sum_reg   <= sum_next;
                hw_reg    <= hw_next;
            end
        end
    end

    // payload phase only with a nonzero in-range length not yet reached
    `ADB_DFC_ASSERT_NOW(a_front_payload_len, clk, rst_n, phase_reg == PH_PAYLOAD, hw_reg[W_LEN][WORD_W-1:MAXP_W] == '0 && bc_reg < hw_reg[W_LEN][MAXP_W-1:0])
    // header skip only after the full header was gathered
    `ADB_DFC_ASSERT_NOW(a_front_skip_full, clk, rst_n, phase_reg == PH_SKIP_HDR, hc_reg == HDR_LIMIT)

endmodule

/* hdl/adb_dfc_back.sv */
// back end: expands queue entries into result transactions
`include "adb_packet_deframer_checker_core_assert.svh"
module adb_dfc_back
    import adb_dfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  entry_t        q_head,
    input  logic          q_empty,
    output logic          q_pop,
    adb_dfc_out_if.source tx
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              sub_reg;
    logic              sub_next;
    kind_t             kind_reg;
    logic [7:0]        byte_reg;
    logic [WORD_W-1:0] cmd_reg;
    logic [WORD_W-1:0] arg0_reg;
    logic [WORD_W-1:0] arg1_reg;
    logic [WORD_W-1:0] len_reg;
    status_t           status_reg;
    logic              last_reg;
    logic              load;
    logic              take;
    logic              byte_sel;

    assign load     = !out_valid_reg || tx.ready;
    assign take     = load && !q_empty;
    // byte half goes first when an entry carries both
    assign byte_sel = q_head.has_byte && !sub_reg;
    assign q_pop    = take && !(byte_sel && q_head.has_sum);

    always_comb
    begin
        out_valid_next = load ? !q_empty : out_valid_reg;
        sub_next       = take ? (byte_sel && q_head.has_sum) : sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (byte_sel)
            begin
                kind_reg   <= KIND_BYTE;
                byte_reg   <= q_head.data;
                cmd_reg    <= '0;
                arg0_reg   <= '0;
                arg1_reg   <= '0;
                len_reg    <= '0;
                status_reg <= ST_OK;
                last_reg   <= !q_head.has_sum;
            end
            else
            begin
                kind_reg   <= KIND_SUMMARY;
                byte_reg   <= '0;
                cmd_reg    <= q_head.cmd;
                arg0_reg   <= q_head.arg0;
                arg1_reg   <= q_head.arg1;
                len_reg    <= q_head.len;
                status_reg <= q_head.status;
                last_reg   <= 1'b1;
            end
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.item_kind      = kind_reg;
    assign tx.payload_byte   = byte_reg;
    assign tx.command_word   = cmd_reg;
    assign tx.first_arg      = arg0_reg;
    assign tx.second_arg     = arg1_reg;
    assign tx.payload_length = len_reg;
    assign tx.status         = status_reg;
    assign tx.is_last        = last_reg;

    // a half-sent entry stays at the head until its summary goes out
    `ADB_DFC_ASSERT_NOW(a_back_split_head, clk, rst_n, sub_reg, !q_empty && q_head.has_byte && q_head.has_sum)

endmodule

/* tb/adb_packet_deframer_checker_core_tb.sv */
// testbench for the adb message deframer and checksum checker top level
`timescale 1ns / 1ps

module adb_packet_deframer_checker_core_tb
    import adb_dfc_pkg::*;
();

    // half clock period, reset length, settle time after the last result, cycle limit
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 680;

    // one predicted result transaction
    typedef struct {
        kind_t       kind;
        logic [7:0]  pbyte;
        logic [31:0] cmd;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic [31:0] len;
        status_t     st;
        logic        last;
    } deframe_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MAXP_W-1:0] cfg_wdata;

    adb_dfc_in_if  rx_if ();
    adb_dfc_out_if res_if ();

    adb_packet_deframer_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx_stream (rx_if),
        .result    (res_if)
    );

    // predicted deframer state, kept in step with every accepted byte
    phase_t            pkt_phase;
    int                hdr_count;
    logic [31:0]       hdr_word [HDR_WORDS];
    logic [31:0]       pay_count;
    logic [31:0]       pay_sum;
    logic [MAXP_W-1:0] max_len_cfg;

    // results still owed by the block, oldest first
    deframe_result_t expected_q [$];
    deframe_result_t seen_exp;

    // payload of the packet being built by a test
    logic [7:0] pay_buf [$];

    int errors;
    int sent_items;
    int cycle_cnt;
    int stall_left;
    bit sender_steady;
    bit sink_steady;

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void clear_state();
        pkt_phase = PH_HEADER;
        hdr_count = 0;
        for (int i = 0; i < HDR_WORDS; i++)
            hdr_word[i] = '0;
        pay_count = '0;
        pay_sum   = '0;
    endfunction

    function automatic status_t sum_status();
        return (pay_sum == hdr_word[W_SUM]) ? ST_OK : ST_SUM_BAD;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        deframe_result_t r;
        r = '{KIND_BYTE, b, '0, '0, '0, '0, ST_OK, 1'b0};
        expected_q.push_back(r);
    endfunction

    // a summary carries the header words and returns everything to reset
    function automatic void close_packet(input status_t st);
        deframe_result_t r;
        r = '{KIND_SUMMARY, 8'h00, hdr_word[W_CMD], hdr_word[W_ARG0], hdr_word[W_ARG1],
              hdr_word[W_LEN], st, 1'b0};
        expected_q.push_back(r);
        clear_state();
    endfunction

    // header chunk ended with all header bytes: magic first, then length
    function automatic void judge_header();
        if (hdr_word[W_MAGIC] != ~hdr_word[W_CMD])
            close_packet(ST_BAD_MAGIC);
        else if (hdr_word[W_LEN] > 32'(max_len_cfg))
            close_packet(ST_TOO_LONG);
        else if (hdr_word[W_LEN] == 0)
            close_packet(sum_status());
        else
        begin
            pkt_phase = PH_PAYLOAD;
            pay_count = '0;
            pay_sum   = '0;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic e);
        int n_owed;
        n_owed = expected_q.size();
        case (pkt_phase)
            PH_HEADER:
            begin
                if (hdr_count < HEADER_BYTES)
                begin
                    hdr_word[hdr_count / 4][8 * (hdr_count % 4) +: 8] = b;
                    hdr_count++;
                end
                if (hdr_count >= HEADER_BYTES)
                    pkt_phase = PH_SKIP_HDR;
                // chunk end on the last header byte is judged right away
                if (e)
                begin
                    if (hdr_count < HEADER_BYTES)
                        close_packet(ST_SHORT);
                    else
                        judge_header();
                end
            end
            PH_SKIP_HDR:
            begin
                if (e)
                    judge_header();
            end
            PH_PAYLOAD:
            begin
                if (pay_count < hdr_word[W_LEN])
                begin
                    push_byte(b);
                    pay_sum   = pay_sum + 32'(b);
                    pay_count = pay_count + 32'd1;
                end
                // byte result first, then the summary when the chunk ends here
                if (pay_count >= hdr_word[W_LEN])
                begin
                    if (e)
                        close_packet(sum_status());
                    else
                        pkt_phase = PH_SKIP_TAIL;
                end
            end
            default:
            begin
                if (e)
                    close_packet(sum_status());
            end
        endcase
        if (expected_q.size() > n_owed)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 32);
        if (r < 95)
            return $urandom_range(33, 200);
        return $urandom_range(201, 600);
    endfunction

    function automatic logic [MAXP_W-1:0] pick_max();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return MAXP_W'(1048576);
        if (r == 2)
            return MAXP_RESET;
        if (r < 5)
            return MAXP_W'($urandom_range(0, 64));
        return MAXP_W'($urandom_range(0, 1048576));
    endfunction

    function automatic logic [31:0] buf_sum();
        logic [31:0] s;
        s = '0;
        foreach (pay_buf[i])
            s = s + 32'(pay_buf[i]);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // result side: ready with random stalls, and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (sink_steady)
            res_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    // every result transaction is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (expected_q.size() == 0)
                report("result with nothing owed, item_kind", 32'(res_if.item_kind), 32'hx);
            else
            begin
                seen_exp = expected_q.pop_front();
                check_field("item_kind", 32'(res_if.item_kind), 32'(seen_exp.kind));
                check_field("payload_byte", 32'(res_if.payload_byte), 32'(seen_exp.pbyte));
                check_field("command_word", res_if.command_word, seen_exp.cmd);
                check_field("first_arg", res_if.first_arg, seen_exp.arg0);
                check_field("second_arg", res_if.second_arg, seen_exp.arg1);
                check_field("payload_length", res_if.payload_length, seen_exp.len);
                check_field("status", 32'(res_if.status), 32'(seen_exp.st));
                check_field("is_last", 32'(res_if.is_last), 32'(seen_exp.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // one byte transaction; valid stays high across back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic e);
        int g;
        g = sender_steady ? 0 : pick_gap();
        if (g > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.data_byte <= b;
        rx_if.chunk_end <= e;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        predict_byte(b, e);
        sent_items++;
    endtask

    // stop sending and wait until the block has nothing left to give
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_len_limit(input logic [MAXP_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        max_len_cfg = v;
    endtask

    // header chunk of hdr_n bytes plus hdr_extra dropped bytes, then pay_buf split
    // into chunks, then tail bytes past the length; pause_at >= 0 drains mid payload
    task automatic send_packet(input logic [31:0] cmd, arg0, arg1, len, chk, magic,
                               input int hdr_n, input int hdr_extra, input int tail,
                               input int split_pct, input int pause_at);
        logic [31:0] w [HDR_WORDS];
        int last_pay;
        w[W_CMD]   = cmd;
        w[W_ARG0]  = arg0;
        w[W_ARG1]  = arg1;
        w[W_LEN]   = len;
        w[W_SUM]   = chk;
        w[W_MAGIC] = magic;
        for (int i = 0; i < hdr_n; i++)
            send_byte(w[i / 4][8 * (i % 4) +: 8], (i == hdr_n - 1) && (hdr_extra == 0));
        for (int i = 0; i < hdr_extra; i++)
            send_byte(8'($urandom_range(0, 255)), i == hdr_extra - 1);
        last_pay = pay_buf.size() - 1;
        for (int i = 0; i <= last_pay; i++)
        begin
            send_byte(pay_buf[i], (i == last_pay) ? (tail == 0)
                                                  : ($urandom_range(0, 99) < split_pct));
            if (i == pause_at)
                drain();
        end
        for (int i = 0; i < tail; i++)
            send_byte(8'($urandom_range(0, 255)), i == tail - 1);
        pay_buf.delete();
    endtask

    // bring the stream back to the start of a header after noise
    task automatic resync();
        while (!(pkt_phase == PH_HEADER && hdr_count == 0))
            send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // chunk ends before all 24 header bytes
    task automatic test_short_header();
        send_packet(32'h0000_0001, 32'h2, 32'h3, 32'h0, 32'h0, ~32'h1, 1, 0, 0, 0, -1);
        send_packet(32'hdead_beef, 32'hffff_ffff, 32'h0, 32'h10, 32'h0, 32'h0,
                    23, 0, 0, 0, -1);
    endtask

    // magic and length checks, zero length packets, dropped header tails
    task automatic test_header_checks();
        // bad magic wins over a too long length
        send_packet(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h1,
                    HEADER_BYTES, 0, 0, 0, -1);
        send_packet(32'h0, 32'h1234_5678, 32'h9abc_def0, 32'd4097, 32'h0, 32'hffff_ffff,
                    HEADER_BYTES, 2, 0, 0, -1);
        send_packet(32'h1234_5678, 32'h1, 32'h2, 32'h0, 32'h0, ~32'h1234_5678,
                    HEADER_BYTES, 3, 0, 0, -1);
        send_packet(32'h4e58_4e43, 32'h1, 32'h2, 32'h0, 32'h5, ~32'h4e58_4e43,
                    HEADER_BYTES, 0, 0, 0, -1);
    endtask

    // payload pass-through, chunk splits, bytes past length, checksum errors
    task automatic test_payload_paths();
        // single byte whose chunk end also closes the packet
        pay_buf = '{8'hff};
        send_packet(32'h0, 32'h0, 32'h0, 32'h1, 32'hff, 32'hffff_ffff,
                    HEADER_BYTES, 0, 0, 0, -1);
        pay_buf = '{8'h00, 8'hff, 8'h5a};
        send_packet(32'h4f50_454e, 32'h7, 32'h8, 32'h3, buf_sum(), ~32'h4f50_454e,
                    HEADER_BYTES, 1, 4, 50, -1);
        pay_buf = '{8'h01, 8'h80, 8'h7f, 8'hfe};
        send_packet(32'h5752_5445, 32'h9, 32'ha, 32'h4, buf_sum() + 32'h1, ~32'h5752_5445,
                    HEADER_BYTES, 0, 0, 30, -1);
    endtask

    // length limit at the edges: equal accepted, one more refused
    task automatic test_length_limit();
        set_len_limit(MAXP_W'(5));
        pay_buf = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        send_packet(32'h1, 32'h0, 32'h0, 32'h5, buf_sum(), ~32'h1, HEADER_BYTES, 0, 0, 20, -1);
        send_packet(32'h1, 32'h0, 32'h0, 32'h6, 32'h0, ~32'h1, HEADER_BYTES, 0, 0, 0, -1);
        set_len_limit('0);
        send_packet(32'h2, 32'h0, 32'h0, 32'h0, 32'h0, ~32'h2, HEADER_BYTES, 0, 0, 0, -1);
        send_packet(32'h2, 32'h0, 32'h0, 32'h1, 32'h0, ~32'h2, HEADER_BYTES, 0, 0, 0, -1);
        set_len_limit(MAXP_W'(1048576));
        send_packet(32'h3, 32'h0, 32'h0, 32'd1048577, 32'h0, ~32'h3,
                    HEADER_BYTES, 0, 0, 0, -1);
        for (int i = 0; i < 40; i++)
            pay_buf.push_back(8'($urandom_range(0, 255)));
        send_packet(32'h3, 32'h0, 32'h0, 32'd40, buf_sum(), ~32'h3, HEADER_BYTES, 0, 2, 10, -1);
        set_len_limit(MAXP_RESET);
    endtask

    // sender holds off mid payload until the block has emptied out
    task automatic test_sender_pause();
        for (int i = 0; i < 12; i++)
            pay_buf.push_back(8'($urandom_range(0, 255)));
        send_packet(32'h7, 32'h1, 32'h2, 32'd12, buf_sum(), ~32'h7, HEADER_BYTES, 0, 1, 0, 5);
    endtask

    // one random packet: mostly well formed, some broken, some plain noise
    task automatic random_packet();
        int r;
        int plen;
        int n;
        int tail;
        int extra;
        logic [31:0] cmd;
        logic [31:0] len;
        logic [31:0] chk;
        logic [31:0] magic;
        r     = $urandom_range(0, 99);
        cmd   = rand_word();
        magic = ~cmd;
        plen  = pick_len();
        if (plen > int'(max_len_cfg))
            plen = $urandom_range(0, int'(max_len_cfg));
        len   = 32'(plen);
        chk   = '0;
        tail  = 0;
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (r < 8)
        begin
            // noise with random chunk ends
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 9) == 0));
            resync();
            return;
        end
        if (r < 14)
        begin
            send_packet(cmd, rand_word(), rand_word(), rand_word(), rand_word(), magic,
                        $urandom_range(1, HEADER_BYTES - 1), 0, 0, 0, -1);
            return;
        end
        if (r < 20)
            magic = magic ^ (rand_word() | 32'h1);
        else if (r < 26)
            len = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff
                                              : 32'(max_len_cfg) + $urandom_range(1, 1000);
        else
        begin
            for (int i = 0; i < plen; i++)
                pay_buf.push_back(8'($urandom_range(0, 255)));
            chk = buf_sum();
            if (r < 34)
                chk = chk + $urandom_range(1, 1000);
            if (r >= 34 && r < 44 && plen > 0)
                tail = $urandom_range(1, 8);
        end
        send_packet(cmd, rand_word(), rand_word(), len, chk, magic,
                    HEADER_BYTES, extra, tail, $urandom_range(0, 30), -1);
    endtask

    task automatic test_random_traffic();
        int start;
        int last_cfg;
        start    = sent_items;
        last_cfg = sent_items;
        while (sent_items - start < RANDOM_ITEMS)
        begin
            // flow control stretches with no idling on either side now and then
            sender_steady = ($urandom_range(0, 9) == 0);
            sink_steady   = ($urandom_range(0, 9) == 0);
            if (sent_items - last_cfg > 250)
            begin
                set_len_limit(pick_max());
                last_cfg = sent_items;
            end
            random_packet();
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rx_if.valid     = 1'b0;
        rx_if.data_byte = '0;
        rx_if.chunk_end = 1'b0;
        res_if.ready    = 1'b0;
        errors          = 0;
        sent_items      = 0;
        stall_left      = 0;
        sender_steady   = 1'b0;
        sink_steady     = 1'b0;
        max_len_cfg     = MAXP_RESET;
        clear_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_header();
        test_header_checks();
        test_payload_paths();
        test_length_limit();
        test_sender_pause();
        test_random_traffic();

        // everything owed must arrive, then a quiet window for strays
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
